FILE: hw/rtl/i2a_pkg.sv
// Shared package for the integer to ASCII formatter.
// Holds conversion kind codes, the reciprocal constant for the divide by ten,
// the digit unit control type and the digit to character mapping.
package i2a_pkg;

   localparam logic [2:0] KIND_CHAR = 3'd0;
   localparam logic [2:0] KIND_SDEC = 3'd1;
   localparam logic [2:0] KIND_UDEC = 3'd2;
   localparam logic [2:0] KIND_HEXL = 3'd3;
   localparam logic [2:0] KIND_HEXU = 3'd4;
   localparam logic [2:0] KIND_PTR  = 3'd5;

   // The quotient n / 10 equals (n * RECIP10) >> RECIP10_SHIFT for every 32-bit n.
   localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
   localparam int          RECIP10_SHIFT = 35;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   typedef struct packed {
      logic mul_en;
      logic hex_mode;
   } digit_ctl_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] c;
      begin
         if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
         end else if (upper) begin
            c = 8'h41 + {4'd0, d - 4'd10};
         end else begin
            c = 8'h61 + {4'd0, d - 4'd10};
         end
         return c;
      end
   endfunction

endpackage

FILE: hw/rtl/i2a_digit_unit.sv
// Shared digit extraction unit: splits the low digit off a value in base ten or sixteen.
// Base ten uses a registered reciprocal multiply; depends on i2a_pkg.
module i2a_digit_unit (
   input  logic                  clock,
   input  i2a_pkg::digit_ctl_type ctl,
   input  logic [63:0]           operand,
   output logic [63:0]           quo,
   output logic [3:0]            digit
);

   logic [63:0] prod_ff;
   logic [63:0] prod_in;
   logic [28:0] q10;
   logic [32:0] q_times10;
   logic [32:0] rem_full;

   assign prod_in = operand[31:0] * i2a_pkg::RECIP10;

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      q10       = prod_ff[63:i2a_pkg::RECIP10_SHIFT];
      q_times10 = {1'b0, q10, 3'd0} + {3'd0, q10, 1'b0};
      rem_full  = {1'b0, operand[31:0]} - q_times10;
      if (ctl.hex_mode) begin
         quo   = {4'd0, operand[63:4]};
         digit = operand[3:0];
      end else begin
         quo   = {35'd0, q10};
         digit = rem_full[3:0];
      end
   end

endmodule

FILE: hw/rtl/integer_to_ascii_formatter_core.sv
// Top level of the integer to ASCII formatter: sequencer, digit stack and output beat.
// Depends on i2a_pkg and i2a_digit_unit.
//
//   channel | dir | tdata              | tuser       | tlast
//   req     | in  | value[63:0]        | req_type    | -
//   rsp     | out | char_out[7:0]      | -           | last
//
// A decimal item passes multiply and split per digit in the shared divide unit
// (up to 10), a hex item the hex state per digit (up to 8, or 16 for a pointer),
// then characters go out as beats. A char item goes straight to its single beat.
// The input is ready only while idle; a stalled output beat holds everything.
// Reset is synchronous and returns the sequencer to idle.
module integer_to_ascii_formatter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // value[63:0]
   input  logic [2:0]  req_tuser,   // req_type[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // char_out[7:0]
   output logic        rsp_tlast
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_SPLIT = 3'd2;
   localparam logic [2:0] S_HEX   = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [63:0] val_ff, val_in;
   logic [4:0]  dcnt_ff, dcnt_in;
   logic [1:0]  lcnt_ff, lcnt_in;
   logic [7:0]  lead0_ff, lead0_in;
   logic [7:0]  lead1_ff, lead1_in;
   logic        upper_ff, upper_in;
   logic [3:0]  dstack_ff [16];
   logic        push;

   i2a_pkg::digit_ctl_type ctl;
   logic [63:0] quo;
   logic [3:0]  digit;
   logic [4:0]  top_idx;
   logic        beat;

   i2a_digit_unit u_digit (
      .clock   (clock),
      .ctl     (ctl),
      .operand (val_ff),
      .quo     (quo),
      .digit   (digit)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_EMIT);
   assign beat       = rsp_tvalid & rsp_tready;
   assign top_idx    = dcnt_ff - 5'd1;

   always_comb begin
      if (lcnt_ff != 2'd0) begin
         rsp_tdata = lead0_ff;
      end else begin
         rsp_tdata = i2a_pkg::digit_char(dstack_ff[top_idx[3:0]], upper_ff);
      end
      rsp_tlast = ((lcnt_ff == 2'd1) && (dcnt_ff == 5'd0))
               || ((lcnt_ff == 2'd0) && (dcnt_ff == 5'd1));
   end

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      dcnt_in      = dcnt_ff;
      lcnt_in      = lcnt_ff;
      lead0_in     = lead0_ff;
      lead1_in     = lead1_ff;
      upper_in     = upper_ff;
      push         = 1'b0;
      ctl.mul_en   = 1'b0;
      ctl.hex_mode = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               dcnt_in  = 5'd0;
               lcnt_in  = 2'd0;
               upper_in = 1'b0;
               val_in   = {32'd0, req_tdata[31:0]};
               case (req_tuser)
                  i2a_pkg::KIND_CHAR: begin
                     lead0_in = req_tdata[7:0];
                     lcnt_in  = 2'd1;
                     state_in = S_EMIT;
                  end
                  i2a_pkg::KIND_SDEC: begin
                     if (req_tdata[31]) begin
                        val_in   = {32'd0, 32'd0 - req_tdata[31:0]};
                        lead0_in = i2a_pkg::CH_MINUS;
                        lcnt_in  = 2'd1;
                     end
                     state_in = S_MUL;
                  end
                  i2a_pkg::KIND_UDEC: begin
                     state_in = S_MUL;
                  end
                  i2a_pkg::KIND_HEXL: begin
                     state_in = S_HEX;
                  end
                  i2a_pkg::KIND_HEXU: begin
                     upper_in = 1'b1;
                     state_in = S_HEX;
                  end
                  i2a_pkg::KIND_PTR: begin
                     val_in   = req_tdata;
                     lead0_in = i2a_pkg::CH_ZERO;
                     lead1_in = i2a_pkg::CH_X;
                     lcnt_in  = 2'd2;
                     state_in = S_HEX;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_MUL: begin
            ctl.mul_en = 1'b1;
            state_in   = S_SPLIT;
         end
         S_SPLIT, S_HEX: begin
            ctl.hex_mode = (state_ff == S_HEX);
            push         = 1'b1;
            dcnt_in      = dcnt_ff + 5'd1;
            val_in       = quo;
            if (quo == 64'd0) begin
               state_in = S_EMIT;
            end else if (state_ff == S_SPLIT) begin
               state_in = S_MUL;
            end
         end
         S_EMIT: begin
            if (beat) begin
               if (lcnt_ff != 2'd0) begin
                  lcnt_in  = lcnt_ff - 2'd1;
                  lead0_in = lead1_ff;
               end else begin
                  dcnt_in = dcnt_ff - 5'd1;
               end
               if (rsp_tlast) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dcnt_ff  <= 5'd0;
         lcnt_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         dcnt_ff  <= dcnt_in;
         lcnt_ff  <= lcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff   <= val_in;
      lead0_ff <= lead0_in;
      lead1_ff <= lead1_in;
      upper_ff <= upper_in;
      if (push) begin
         dstack_ff[dcnt_ff[3:0]] <= digit;
      end
   end

endmodule
